// ----- sv/altitude_hold_cascaded_pid_top_assert.svh -----
// Assertion macros for the altitude hold block checker.
// Included by the checker file only; no other dependencies.
`ifndef ALTITUDE_HOLD_CASCADED_PID_TOP_ASSERT_SVH
`define ALTITUDE_HOLD_CASCADED_PID_TOP_ASSERT_SVH

// same-cycle implication
`define AHCP_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ahcp assertion failed");

// next-cycle implication
`define AHCP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ahcp assertion failed");

`endif

// ----- sv/ahcp_pkg.sv -----
// Shared widths, limits, codes and helper functions for the altitude hold block.
// No dependencies; used by the interfaces and the top level.
`default_nettype none
package ahcp_pkg;

   localparam int ALT_W      = 21;
   localparam int VEL_W      = 16;
   localparam int ACC_W      = 16;
   localparam int TILT_W     = 12;
   localparam int THR_W      = 11;
   localparam int GAIN_W     = 8;
   localparam int DB_W       = 8;
   localparam int INTEG_W    = 22;
   localparam int ADJ_W      = 11;
   localparam int OP_W       = 2;
   localparam int MB_W       = 18;
   localparam int PROD_W     = GAIN_W + 1 + MB_W;
   localparam int WIDE_W     = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam int TILT_LIMIT    = 800;
   localparam int ALT_ERR_LIMIT = 500;
   localparam int ALT_DEADBAND  = 10;
   localparam int VEL_LIMIT     = 300;
   localparam int P_LIMIT       = 300;
   localparam int I_LIMIT       = 8192 * 200;
   localparam int D_LIMIT       = 150;
   localparam int THR_CEIL      = 2047;
   localparam int ALT_P_SHIFT   = 7;
   localparam int VEL_P_SHIFT   = 5;
   localparam int VEL_I_SHIFT   = 13;
   localparam int VEL_D_SHIFT   = 9;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_SWITCH = 2'd1,
      OP_APPLY  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ALT_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_P    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_I    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_D    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_MIN  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_MAX  = 3'd7;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_ALT  = 9'b000000010,
      S_VEL  = 9'b000000100,
      S_PMUL = 9'b000001000,
      S_IMUL = 9'b000010000,
      S_DMUL = 9'b000100000,
      S_SUM  = 9'b001000000,
      S_EXEC = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   typedef logic signed [WIDE_W-1:0] wide_type;

   // symmetric saturation to +-lim
   function automatic wide_type sat(input wide_type x, input int lim);
      wide_type r;
      if (x > lim) r = WIDE_W'(lim);
      else if (x < -lim) r = WIDE_W'(-lim);
      else r = x;
      return r;
   endfunction

   // arithmetic right shift rounding toward zero
   function automatic wide_type trunc_shr(input wide_type x, input int sh);
      wide_type bias;
      wide_type r;
      bias = x[WIDE_W-1] ? WIDE_W'((1 << sh) - 1) : '0;
      r = (x + bias) >>> sh;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- sv/ahcp_ifs.sv -----
// Handshake interfaces for the altitude hold block: request, response, csr write.
// Depends on ahcp_pkg for field widths.
`default_nettype none
interface ahcp_req_if;
   logic                                valid;
   logic                                ready;
   logic [ahcp_pkg::OP_W-1:0]           opcode;
   logic signed [ahcp_pkg::ALT_W-1:0]   est_altitude;
   logic signed [ahcp_pkg::VEL_W-1:0]   est_velocity;
   logic signed [ahcp_pkg::ACC_W-1:0]   accel_z;
   logic signed [ahcp_pkg::TILT_W-1:0]  roll_tilt;
   logic signed [ahcp_pkg::TILT_W-1:0]  pitch_tilt;
   logic                                hold_switch;
   logic [ahcp_pkg::THR_W-1:0]          stick_throttle;
   logic [ahcp_pkg::THR_W-1:0]          throttle_command;

   modport source (output valid, opcode, est_altitude, est_velocity, accel_z, roll_tilt,
                   pitch_tilt, hold_switch, stick_throttle, throttle_command,
                   input ready);
   modport sink (input valid, opcode, est_altitude, est_velocity, accel_z, roll_tilt,
                 pitch_tilt, hold_switch, stick_throttle, throttle_command,
                 output ready);
endinterface

interface ahcp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ahcp_pkg::ADJ_W-1:0]   throttle_adjust;
   logic [ahcp_pkg::THR_W-1:0]          throttle_out;
   logic                                hold_engaged;
   logic                                velocity_mode;

   modport source (output valid, throttle_adjust, throttle_out, hold_engaged, velocity_mode,
                   input ready);
   modport sink (input valid, throttle_adjust, throttle_out, hold_engaged, velocity_mode,
                 output ready);
endinterface

interface ahcp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ahcp_pkg::CSR_IDX_W-1:0]      reg_index;
   logic [ahcp_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ----- sv/altitude_hold_cascaded_pid_top.sv -----
// Cascaded altitude / vertical velocity PID for multirotor altitude hold.
// One word in gives one word out. A tick word (opcode 0) runs S_ALT, S_VEL, S_PMUL,
// S_IMUL, S_DMUL, S_SUM and S_DONE (from S_ALT to S_DONE when tilted), the altitude and
// velocity loop terms sharing one 9x18 signed multiplier, each product registered before
// use. Switch, stick and unused opcodes run S_EXEC and S_DONE. The input is not ready while
// a word is in work; a new word is taken while the previous result waits on the output.
// Csr writes are always ready and apply on the cycle they are taken.
// Depends on ahcp_pkg and the interfaces in ahcp_ifs.sv.
`default_nettype none
module altitude_hold_cascaded_pid_top (
   input  wire logic    clock,
   input  wire logic    reset,
   ahcp_req_if.sink     req_ch,
   ahcp_rsp_if.source   rsp_ch,
   ahcp_csr_if.sink     csr_ch
);

   ahcp_pkg::state_type state_ff, state_in;

   logic [ahcp_pkg::GAIN_W-1:0] alt_p_ff, alt_p_in, vel_p_ff, vel_p_in;
   logic [ahcp_pkg::GAIN_W-1:0] vel_i_ff, vel_i_in, vel_d_ff, vel_d_in;
   logic [ahcp_pkg::DB_W-1:0]   deadband_ff, deadband_in;
   logic                        fast_ff, fast_in;
   logic [ahcp_pkg::THR_W-1:0]  thr_min_ff, thr_min_in, thr_max_ff, thr_max_in;

   ahcp_pkg::opcode_type              op_ff, op_in;
   logic signed [ahcp_pkg::ALT_W-1:0]  cur_alt_ff, cur_alt_in;
   logic signed [ahcp_pkg::VEL_W-1:0]  cur_vel_ff, cur_vel_in;
   logic signed [ahcp_pkg::ACC_W-1:0]  cur_acc_ff, cur_acc_in;
   logic signed [ahcp_pkg::TILT_W-1:0] cur_roll_ff, cur_roll_in, cur_pitch_ff, cur_pitch_in;
   logic                               cur_sw_ff, cur_sw_in;
   logic [ahcp_pkg::THR_W-1:0]         cur_stick_ff, cur_stick_in;

   logic signed [ahcp_pkg::ALT_W-1:0]   alt_target_ff, alt_target_in;
   logic signed [ahcp_pkg::ALT_W-1:0]   last_alt_ff, last_alt_in;
   logic signed [ahcp_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ahcp_pkg::ACC_W-1:0]   prev_acc_ff, prev_acc_in;
   logic [ahcp_pkg::THR_W-1:0]          hold_thr_ff, hold_thr_in;
   logic signed [ahcp_pkg::ADJ_W-1:0]   adjust_ff, adjust_in;
   logic signed [ahcp_pkg::THR_W-1:0]   vsp_ff, vsp_in;
   logic                                vflag_ff, vflag_in;
   logic                                changed_ff, changed_in;
   logic                                engaged_ff, engaged_in;

   logic signed [ahcp_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ahcp_pkg::MB_W-1:0]   verr_ff, verr_in;
   logic signed [ahcp_pkg::ADJ_W-1:0]  pterm_ff, pterm_in;
   logic [ahcp_pkg::THR_W-1:0]         tout_ff, tout_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [ahcp_pkg::ADJ_W-1:0]  rsp_adj_ff, rsp_adj_in;
   logic [ahcp_pkg::THR_W-1:0]         rsp_tout_ff, rsp_tout_in;
   logic                               rsp_eng_ff, rsp_eng_in;
   logic                               rsp_vm_ff, rsp_vm_in;

   logic [ahcp_pkg::GAIN_W-1:0]        mul_a;
   logic signed [ahcp_pkg::MB_W-1:0]   mul_b;
   logic signed [ahcp_pkg::PROD_W-1:0] mul_p;

   ahcp_pkg::wide_type roll_w, pitch_w, alt_w, target_w, vel_w, acc_w, prev_acc_w;
   ahcp_pkg::wide_type prod_w, integ_w, pterm_w, vsp_w, adjust_w, hold_w, stick_w;
   ahcp_pkg::wide_type cmd_w, db_w, min_w, max_w;
   ahcp_pkg::wide_type alt_err_c, alt_err_db, setv_w, dterm_w, res_w, diff_w, held_t;
   ahcp_pkg::wide_type fast_t, held_w, fast_w;
   logic tilt_ok, outside, req_take, rsp_free;

   assign roll_w     = ahcp_pkg::WIDE_W'(cur_roll_ff);
   assign pitch_w    = ahcp_pkg::WIDE_W'(cur_pitch_ff);
   assign alt_w      = ahcp_pkg::WIDE_W'(cur_alt_ff);
   assign target_w   = ahcp_pkg::WIDE_W'(alt_target_ff);
   assign vel_w      = ahcp_pkg::WIDE_W'(cur_vel_ff);
   assign acc_w      = ahcp_pkg::WIDE_W'(cur_acc_ff);
   assign prev_acc_w = ahcp_pkg::WIDE_W'(prev_acc_ff);
   assign prod_w     = ahcp_pkg::WIDE_W'(prod_ff);
   assign integ_w    = ahcp_pkg::WIDE_W'(integ_ff);
   assign pterm_w    = ahcp_pkg::WIDE_W'(pterm_ff);
   assign vsp_w      = ahcp_pkg::WIDE_W'(vsp_ff);
   assign adjust_w   = ahcp_pkg::WIDE_W'(adjust_ff);
   assign hold_w     = ahcp_pkg::WIDE_W'(hold_thr_ff);
   assign stick_w    = ahcp_pkg::WIDE_W'(cur_stick_ff);
   assign cmd_w      = ahcp_pkg::WIDE_W'(tout_ff);
   assign db_w       = ahcp_pkg::WIDE_W'(deadband_ff);
   assign min_w      = ahcp_pkg::WIDE_W'(thr_min_ff);
   assign max_w      = ahcp_pkg::WIDE_W'(thr_max_ff);

   assign tilt_ok = (roll_w < ahcp_pkg::TILT_LIMIT) && (roll_w > -ahcp_pkg::TILT_LIMIT) &&
                    (pitch_w < ahcp_pkg::TILT_LIMIT) && (pitch_w > -ahcp_pkg::TILT_LIMIT);

   // altitude error with deadband
   assign alt_err_c = ahcp_pkg::sat(target_w - alt_w, ahcp_pkg::ALT_ERR_LIMIT);
   always_comb begin
      if (alt_err_c <= ahcp_pkg::ALT_DEADBAND && alt_err_c >= -ahcp_pkg::ALT_DEADBAND) begin
         alt_err_db = '0;
      end else if (alt_err_c > 0) begin
         alt_err_db = alt_err_c - ahcp_pkg::WIDE_W'(ahcp_pkg::ALT_DEADBAND);
      end else begin
         alt_err_db = alt_err_c + ahcp_pkg::WIDE_W'(ahcp_pkg::ALT_DEADBAND);
      end
   end

   assign setv_w = vflag_ff ? vsp_w
                 : ahcp_pkg::sat(ahcp_pkg::trunc_shr(prod_w, ahcp_pkg::ALT_P_SHIFT),
                                 ahcp_pkg::VEL_LIMIT);
   assign dterm_w = ahcp_pkg::sat(ahcp_pkg::trunc_shr(prod_w, ahcp_pkg::VEL_D_SHIFT),
                                  ahcp_pkg::D_LIMIT);
   assign res_w = pterm_w + ahcp_pkg::trunc_shr(integ_w, ahcp_pkg::VEL_I_SHIFT) - dterm_w;

   // stick handling
   assign diff_w  = stick_w - hold_w;
   assign outside = (diff_w > db_w) || (diff_w < -db_w);
   assign held_t  = hold_w + adjust_w;
   assign held_w  = (held_t < min_w) ? min_w : ((held_t > max_w) ? max_w : held_t);
   assign fast_t  = (diff_w > 0) ? (cmd_w - db_w) : (cmd_w + db_w);
   assign fast_w  = (fast_t < 0) ? '0
                  : ((fast_t > ahcp_pkg::THR_CEIL) ?
                     ahcp_pkg::WIDE_W'(ahcp_pkg::THR_CEIL) : fast_t);

   // shared multiplier
   always_comb begin
      case (state_ff)
         ahcp_pkg::S_ALT: begin
            mul_a = alt_p_ff;
            mul_b = ahcp_pkg::MB_W'(alt_err_db);
         end
         ahcp_pkg::S_PMUL: begin
            mul_a = vel_p_ff;
            mul_b = verr_ff;
         end
         ahcp_pkg::S_IMUL: begin
            mul_a = vel_i_ff;
            mul_b = verr_ff;
         end
         ahcp_pkg::S_DMUL: begin
            mul_a = vel_d_ff;
            mul_b = ahcp_pkg::MB_W'(acc_w + prev_acc_w);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = $signed({1'b0, mul_a}) * mul_b;

   assign req_ch.ready = (state_ff == ahcp_pkg::S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      alt_p_in      = alt_p_ff;
      vel_p_in      = vel_p_ff;
      vel_i_in      = vel_i_ff;
      vel_d_in      = vel_d_ff;
      deadband_in   = deadband_ff;
      fast_in       = fast_ff;
      thr_min_in    = thr_min_ff;
      thr_max_in    = thr_max_ff;
      op_in         = op_ff;
      cur_alt_in    = cur_alt_ff;
      cur_vel_in    = cur_vel_ff;
      cur_acc_in    = cur_acc_ff;
      cur_roll_in   = cur_roll_ff;
      cur_pitch_in  = cur_pitch_ff;
      cur_sw_in     = cur_sw_ff;
      cur_stick_in  = cur_stick_ff;
      alt_target_in = alt_target_ff;
      last_alt_in   = last_alt_ff;
      integ_in      = integ_ff;
      prev_acc_in   = prev_acc_ff;
      hold_thr_in   = hold_thr_ff;
      adjust_in     = adjust_ff;
      vsp_in        = vsp_ff;
      vflag_in      = vflag_ff;
      changed_in    = changed_ff;
      engaged_in    = engaged_ff;
      prod_in       = prod_ff;
      verr_in       = verr_ff;
      pterm_in      = pterm_ff;
      tout_in       = tout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_adj_in    = rsp_adj_ff;
      rsp_tout_in   = rsp_tout_ff;
      rsp_eng_in    = rsp_eng_ff;
      rsp_vm_in     = rsp_vm_ff;

      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            ahcp_pkg::CSR_ALT_P:    alt_p_in    = csr_ch.wdata[ahcp_pkg::GAIN_W-1:0];
            ahcp_pkg::CSR_VEL_P:    vel_p_in    = csr_ch.wdata[ahcp_pkg::GAIN_W-1:0];
            ahcp_pkg::CSR_VEL_I:    vel_i_in    = csr_ch.wdata[ahcp_pkg::GAIN_W-1:0];
            ahcp_pkg::CSR_VEL_D:    vel_d_in    = csr_ch.wdata[ahcp_pkg::GAIN_W-1:0];
            ahcp_pkg::CSR_DEADBAND: deadband_in = csr_ch.wdata[ahcp_pkg::DB_W-1:0];
            ahcp_pkg::CSR_FAST:     fast_in     = csr_ch.wdata[0];
            ahcp_pkg::CSR_THR_MIN:  thr_min_in  = csr_ch.wdata[ahcp_pkg::THR_W-1:0];
            ahcp_pkg::CSR_THR_MAX:  thr_max_in  = csr_ch.wdata[ahcp_pkg::THR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ahcp_pkg::S_IDLE: begin
            if (req_take) begin
               op_in        = ahcp_pkg::opcode_type'(req_ch.opcode);
               cur_alt_in   = req_ch.est_altitude;
               cur_vel_in   = req_ch.est_velocity;
               cur_acc_in   = req_ch.accel_z;
               cur_roll_in  = req_ch.roll_tilt;
               cur_pitch_in = req_ch.pitch_tilt;
               cur_sw_in    = req_ch.hold_switch;
               cur_stick_in = req_ch.stick_throttle;
               tout_in      = req_ch.throttle_command;
               if (req_ch.opcode == ahcp_pkg::OP_TICK) begin
                  last_alt_in = req_ch.est_altitude;
                  state_in    = ahcp_pkg::S_ALT;
               end else begin
                  state_in = ahcp_pkg::S_EXEC;
               end
            end
         end
         ahcp_pkg::S_ALT: begin
            prod_in = mul_p;
            if (tilt_ok) begin
               state_in = ahcp_pkg::S_VEL;
            end else begin
               adjust_in   = '0;
               prev_acc_in = cur_acc_ff;
               state_in    = ahcp_pkg::S_DONE;
            end
         end
         ahcp_pkg::S_VEL: begin
            verr_in  = ahcp_pkg::MB_W'(setv_w - vel_w);
            state_in = ahcp_pkg::S_PMUL;
         end
         ahcp_pkg::S_PMUL: begin
            prod_in  = mul_p;
            state_in = ahcp_pkg::S_IMUL;
         end
         ahcp_pkg::S_IMUL: begin
            pterm_in = ahcp_pkg::ADJ_W'(ahcp_pkg::sat(
                          ahcp_pkg::trunc_shr(prod_w, ahcp_pkg::VEL_P_SHIFT),
                          ahcp_pkg::P_LIMIT));
            prod_in  = mul_p;
            state_in = ahcp_pkg::S_DMUL;
         end
         ahcp_pkg::S_DMUL: begin
            integ_in = ahcp_pkg::INTEG_W'(ahcp_pkg::sat(integ_w + prod_w, ahcp_pkg::I_LIMIT));
            prod_in  = mul_p;
            state_in = ahcp_pkg::S_SUM;
         end
         ahcp_pkg::S_SUM: begin
            adjust_in   = ahcp_pkg::ADJ_W'(res_w);
            prev_acc_in = cur_acc_ff;
            state_in    = ahcp_pkg::S_DONE;
         end
         ahcp_pkg::S_EXEC: begin
            state_in = ahcp_pkg::S_DONE;
            case (op_ff)
               ahcp_pkg::OP_SWITCH: begin
                  if (!cur_sw_ff) begin
                     engaged_in = 1'b0;
                  end else if (!engaged_ff) begin
                     engaged_in    = 1'b1;
                     alt_target_in = last_alt_ff;
                     hold_thr_in   = cur_stick_ff;
                     integ_in      = '0;
                     adjust_in     = '0;
                  end
               end
               ahcp_pkg::OP_APPLY: begin
                  if (engaged_ff) begin
                     if (fast_ff) begin
                        if (outside) begin
                           integ_in   = '0;
                           changed_in = 1'b1;
                           tout_in    = ahcp_pkg::THR_W'(fast_w);
                        end else begin
                           if (changed_ff) begin
                              alt_target_in = last_alt_ff;
                              changed_in    = 1'b0;
                           end
                           tout_in = ahcp_pkg::THR_W'(held_w);
                        end
                     end else begin
                        if (outside) begin
                           vsp_in     = ahcp_pkg::THR_W'(ahcp_pkg::trunc_shr(diff_w, 1));
                           vflag_in   = 1'b1;
                           changed_in = 1'b1;
                        end else if (changed_ff) begin
                           alt_target_in = last_alt_ff;
                           vflag_in      = 1'b0;
                           changed_in    = 1'b0;
                        end
                        tout_in = ahcp_pkg::THR_W'(held_w);
                     end
                  end
               end
               default: ;
            endcase
         end
         ahcp_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_adj_in   = adjust_ff;
               rsp_tout_in  = tout_ff;
               rsp_eng_in   = engaged_ff;
               rsp_vm_in    = vflag_ff;
               state_in     = ahcp_pkg::S_IDLE;
            end
         end
         default: state_in = ahcp_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ahcp_pkg::S_IDLE;
         alt_p_ff      <= 8'd50;
         vel_p_ff      <= 8'd120;
         vel_i_ff      <= 8'd45;
         vel_d_ff      <= 8'd1;
         deadband_ff   <= 8'd40;
         fast_ff       <= 1'b1;
         thr_min_ff    <= 11'd1150;
         thr_max_ff    <= 11'd1850;
         alt_target_ff <= '0;
         last_alt_ff   <= '0;
         integ_ff      <= '0;
         prev_acc_ff   <= '0;
         hold_thr_ff   <= '0;
         adjust_ff     <= '0;
         vsp_ff        <= '0;
         vflag_ff      <= 1'b0;
         changed_ff    <= 1'b0;
         engaged_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alt_p_ff      <= alt_p_in;
         vel_p_ff      <= vel_p_in;
         vel_i_ff      <= vel_i_in;
         vel_d_ff      <= vel_d_in;
         deadband_ff   <= deadband_in;
         fast_ff       <= fast_in;
         thr_min_ff    <= thr_min_in;
         thr_max_ff    <= thr_max_in;
         alt_target_ff <= alt_target_in;
         last_alt_ff   <= last_alt_in;
         integ_ff      <= integ_in;
         prev_acc_ff   <= prev_acc_in;
         hold_thr_ff   <= hold_thr_in;
         adjust_ff     <= adjust_in;
         vsp_ff        <= vsp_in;
         vflag_ff      <= vflag_in;
         changed_ff    <= changed_in;
         engaged_ff    <= engaged_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cur_alt_ff   <= cur_alt_in;
      cur_vel_ff   <= cur_vel_in;
      cur_acc_ff   <= cur_acc_in;
      cur_roll_ff  <= cur_roll_in;
      cur_pitch_ff <= cur_pitch_in;
      cur_sw_ff    <= cur_sw_in;
      cur_stick_ff <= cur_stick_in;
      prod_ff      <= prod_in;
      verr_ff      <= verr_in;
      pterm_ff     <= pterm_in;
      tout_ff      <= tout_in;
      rsp_adj_ff   <= rsp_adj_in;
      rsp_tout_ff  <= rsp_tout_in;
      rsp_eng_ff   <= rsp_eng_in;
      rsp_vm_ff    <= rsp_vm_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.throttle_adjust = rsp_adj_ff;
   assign rsp_ch.throttle_out    = rsp_tout_ff;
   assign rsp_ch.hold_engaged    = rsp_eng_ff;
   assign rsp_ch.velocity_mode   = rsp_vm_ff;

endmodule
`default_nettype wire

// ----- sv/ahcp_checker.sv -----
// Port-level checker for the altitude hold block, bound to the top level.
// Depends on ahcp_pkg and altitude_hold_cascaded_pid_top_assert.svh.
`default_nettype none
`include "altitude_hold_cascaded_pid_top_assert.svh"
module ahcp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [ahcp_pkg::ADJ_W-1:0]  rsp_throttle_adjust,
   input wire logic [ahcp_pkg::THR_W-1:0]         rsp_throttle_out,
   input wire logic                               rsp_hold_engaged,
   input wire logic                               rsp_velocity_mode
);

   `AHCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_throttle_adjust) && $stable(rsp_throttle_out) && $stable(rsp_hold_engaged) && $stable(rsp_velocity_mode))
   `AHCP_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `AHCP_ASSERT_SAME(a_adjust_range, clock, reset, rsp_valid, rsp_throttle_adjust >= -650 && rsp_throttle_adjust <= 650)
   `AHCP_ASSERT_SAME(a_result_after_work, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind altitude_hold_cascaded_pid_top ahcp_checker u_ahcp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_throttle_adjust (rsp_ch.throttle_adjust),
   .rsp_throttle_out    (rsp_ch.throttle_out),
   .rsp_hold_engaged    (rsp_ch.hold_engaged),
   .rsp_velocity_mode   (rsp_ch.velocity_mode)
);
`default_nettype wire

// ----- dv/tb_altitude_hold_cascaded_pid_top.sv -----
// Testbench for the altitude hold block: directed words, then random words over several
// register settings; results checked against table entries or an in-bench hold loop model.
// Depends on ahcp_pkg, the interfaces in ahcp_ifs.sv and altitude_hold_cascaded_pid_top.
`default_nettype none
module tb_altitude_hold_cascaded_pid_top;
   import ahcp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int NUM_DIRECTED = 24;
   localparam int NUM_SETTINGS = 6;
   localparam int WORDS_PER_SETTING = 215;

   typedef struct {
      opcode_type               op;
      logic signed [ALT_W-1:0]  alt;
      logic signed [VEL_W-1:0]  vel;
      logic signed [ACC_W-1:0]  acc;
      logic signed [TILT_W-1:0] roll;
      logic signed [TILT_W-1:0] pitch;
      logic                     sw;
      logic [THR_W-1:0]         stick;
      logic [THR_W-1:0]         cmd;
   } hold_word_t;

   typedef struct {
      logic signed [ADJ_W-1:0] adjust;
      logic [THR_W-1:0]        tout;
      logic                    engaged;
      logic                    vmode;
   } hold_result_t;

   typedef struct {
      hold_word_t   w;
      bit           typed;
      hold_result_t want;
   } directed_row_t;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER[8] = '{CSR_ALT_P, CSR_VEL_P, CSR_VEL_I,
      CSR_VEL_D, CSR_DEADBAND, CSR_FAST, CSR_THR_MIN, CSR_THR_MAX};

   // -1 picks a random legal value
   localparam int SETTINGS_TABLE[NUM_SETTINGS][8] = '{
      '{50, 120, 45, 1, 40, 1, 1150, 1850},
      '{255, 255, 255, 255, 255, 0, 0, 2047},
      '{0, 0, 0, 0, 0, 1, 0, 2047},
      '{-1, -1, -1, -1, -1, 0, 1900, 1200},
      '{-1, -1, -1, -1, -1, 1, 1500, 1500},
      '{-1, -1, -1, -1, -1, -1, -1, -1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ahcp_req_if req_if();
   ahcp_rsp_if rsp_if();
   ahcp_csr_if csr_if();

   altitude_hold_cascaded_pid_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register shadow
   int gain_alt_p = 50, gain_vel_p = 120, gain_vel_i = 45, gain_vel_d = 1;
   int stick_db = 40, fast_mode = 1, thr_lo = 1150, thr_hi = 1850;

   // loop state
   logic signed [ALT_W-1:0]   tgt_alt = '0;
   logic signed [ALT_W-1:0]   seen_alt = '0;
   logic signed [INTEG_W-1:0] integ_acc = '0;
   logic signed [ACC_W-1:0]   acc_prev = '0;
   logic [THR_W-1:0]          hold_thr = '0;
   logic signed [ADJ_W-1:0]   adj_now = '0;
   logic signed [ADJ_W-1:0]   climb_sp = '0;
   bit climb_mode = 1'b0, stick_moved = 1'b0, engaged = 1'b0;

   hold_result_t expected_q[$];
   int errors = 0;
   int words_done = 0;
   int cycles = 0;
   int rsp_hold = 0;
   int alt_home = 0;
   bit calm = 1'b0;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint mag(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int srand(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                        : int'($urandom_range(10, 40));
   endfunction

   function automatic longint held_throttle();
      longint t;
      t = longint'(hold_thr) + longint'(adj_now);
      if (t < thr_lo) return thr_lo;
      if (t > thr_hi) return thr_hi;
      return t;
   endfunction

   // estimator tick: altitude P loop feeding velocity PID
   function automatic longint climb_pid(input hold_word_t w);
      longint err, setv, res, dterm;
      if (!(mag(w.roll) < TILT_LIMIT && mag(w.pitch) < TILT_LIMIT)) return 0;
      if (!climb_mode) begin
         err = clip(longint'(tgt_alt) - longint'(w.alt), -ALT_ERR_LIMIT, ALT_ERR_LIMIT);
         if (mag(err) <= ALT_DEADBAND) err = 0;
         else err = (err > 0) ? err - ALT_DEADBAND : err + ALT_DEADBAND;
         setv = clip(gain_alt_p * err / 128, -VEL_LIMIT, VEL_LIMIT);
      end else begin
         setv = longint'(climb_sp);
      end
      err = setv - longint'(w.vel);
      res = clip(gain_vel_p * err / 32, -P_LIMIT, P_LIMIT);
      integ_acc = clip(longint'(integ_acc) + gain_vel_i * err, -I_LIMIT, I_LIMIT);
      res += longint'(integ_acc) / 8192;
      dterm = clip(gain_vel_d * (longint'(w.acc) + longint'(acc_prev)) / 512,
                   -D_LIMIT, D_LIMIT);
      return res - dterm;
   endfunction

   function automatic hold_result_t advance_hold(input hold_word_t w);
      hold_result_t r;
      longint diff;
      bit outside;
      r.tout = w.cmd;
      case (w.op)
         OP_TICK: begin
            seen_alt = w.alt;
            adj_now = climb_pid(w);
            acc_prev = w.acc;
         end
         OP_SWITCH: begin
            if (!w.sw) begin
               engaged = 1'b0;
            end else if (!engaged) begin
               engaged = 1'b1;
               tgt_alt = seen_alt;
               hold_thr = w.stick;
               integ_acc = '0;
               adj_now = '0;
            end
         end
         OP_APPLY: begin
            if (engaged) begin
               diff = longint'(w.stick) - longint'(hold_thr);
               outside = mag(diff) > stick_db;
               if (fast_mode != 0) begin
                  if (outside) begin
                     integ_acc = '0;
                     stick_moved = 1'b1;
                     r.tout = clip((diff > 0) ? longint'(w.cmd) - stick_db
                                              : longint'(w.cmd) + stick_db, 0, THR_CEIL);
                  end else begin
                     if (stick_moved) begin
                        tgt_alt = seen_alt;
                        stick_moved = 1'b0;
                     end
                     r.tout = held_throttle();
                  end
               end else begin
                  if (outside) begin
                     climb_sp = diff / 2;
                     climb_mode = 1'b1;
                     stick_moved = 1'b1;
                  end else if (stick_moved) begin
                     tgt_alt = seen_alt;
                     climb_mode = 1'b0;
                     stick_moved = 1'b0;
                  end
                  r.tout = held_throttle();
               end
            end
         end
         default: ;
      endcase
      r.adjust = adj_now;
      r.engaged = engaged;
      r.vmode = climb_mode;
      return r;
   endfunction

   function automatic directed_row_t mk(input opcode_type op, input int alt, input int vel,
         input int acc, input int roll, input int pitch, input bit sw, input int stick,
         input int cmd, input bit typed, input int e_adj, input int e_out, input bit e_eng,
         input bit e_vm);
      directed_row_t d;
      d.w.op = op;
      d.w.alt = alt;
      d.w.vel = vel;
      d.w.acc = acc;
      d.w.roll = roll;
      d.w.pitch = pitch;
      d.w.sw = sw;
      d.w.stick = stick;
      d.w.cmd = cmd;
      d.typed = typed;
      d.want.adjust = e_adj;
      d.want.tout = e_out;
      d.want.engaged = e_eng;
      d.want.vmode = e_vm;
      return d;
   endfunction

   function automatic hold_word_t random_word();
      hold_word_t w;
      int r;
      r = $urandom_range(0, 99);
      w.op = (r < 48) ? OP_TICK : (r < 60) ? OP_SWITCH : (r < 97) ? OP_APPLY : OP_NOP;
      alt_home = int'(clip(alt_home + srand(60), -1000000, 1000000));
      w.alt = ($urandom_range(0, 19) == 0) ? srand(1000000)
                                           : int'(clip(alt_home + srand(700), -1000000, 1000000));
      w.vel = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : srand(400);
      w.acc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : srand(2000);
      w.roll = ($urandom_range(0, 6) == 0) ? srand(1800) : srand(900);
      w.pitch = ($urandom_range(0, 6) == 0) ? srand(1800) : srand(900);
      w.sw = ($urandom_range(0, 4) != 0);
      w.stick = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2047)
                                            : clip(hold_thr + srand(stick_db + 80), 0, THR_CEIL);
      w.cmd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1000, 2000);
      return w;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (errors < 40)
         $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
      errors++;
   endtask

   task automatic send_word(input hold_word_t w, input bit typed, input hold_result_t want);
      int gap;
      hold_result_t pred;
      gap = calm ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= w.op;
      req_if.est_altitude <= w.alt;
      req_if.est_velocity <= w.vel;
      req_if.accel_z <= w.acc;
      req_if.roll_tilt <= w.roll;
      req_if.pitch_tilt <= w.pitch;
      req_if.hold_switch <= w.sw;
      req_if.stick_throttle <= w.stick;
      req_if.throttle_command <= w.cmd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pred = advance_hold(w);
      expected_q.push_back(typed ? want : pred);
      words_done++;
   endtask

   // leaves valid high; caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_if.valid <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_ALT_P:    gain_alt_p = val & 8'hFF;
         CSR_VEL_P:    gain_vel_p = val & 8'hFF;
         CSR_VEL_I:    gain_vel_i = val & 8'hFF;
         CSR_VEL_D:    gain_vel_d = val & 8'hFF;
         CSR_DEADBAND: stick_db = val & 8'hFF;
         CSR_FAST:     fast_mode = val & 1;
         CSR_THR_MIN:  thr_lo = val & 11'h7FF;
         CSR_THR_MAX:  thr_hi = val & 11'h7FF;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", expected_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   // result sink: random stalls, none while calm
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin : rsp_check
      hold_result_t want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            report_mismatch("word with nothing expected", rsp_if.throttle_out, -1);
         end else begin
            want = expected_q.pop_front();
            if (rsp_if.throttle_adjust !== want.adjust)
               report_mismatch("throttle_adjust", rsp_if.throttle_adjust, want.adjust);
            if (rsp_if.throttle_out !== want.tout)
               report_mismatch("throttle_out", rsp_if.throttle_out, want.tout);
            if (rsp_if.hold_engaged !== want.engaged)
               report_mismatch("hold_engaged", rsp_if.hold_engaged, want.engaged);
            if (rsp_if.velocity_mode !== want.vmode)
               report_mismatch("velocity_mode", rsp_if.velocity_mode, want.vmode);
         end
      end
   end

   initial begin
      directed_row_t rows[NUM_DIRECTED];
      hold_result_t none;
      int v;
      req_if.valid = 1'b0;
      req_if.opcode = OP_NOP;
      req_if.est_altitude = '0;
      req_if.est_velocity = '0;
      req_if.accel_z = '0;
      req_if.roll_tilt = '0;
      req_if.pitch_tilt = '0;
      req_if.hold_switch = 1'b0;
      req_if.stick_throttle = '0;
      req_if.throttle_command = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.reg_index = CSR_ALT_P;
      csr_if.wdata = '0;
      none = '{adjust: '0, tout: '0, engaged: 1'b0, vmode: 1'b0};

      rows = '{
         mk(OP_NOP,          0,      0,      0,     0,     0, 0,    0, 1234, 1, 0, 1234, 0, 0),
         mk(OP_APPLY,        0,      0,      0,     0,     0, 0, 2047,    0, 1, 0,    0, 0, 0),
         mk(OP_TICK,   1000000,  32767,  32767,   800,     0, 0,    0, 2047, 1, 0, 2047, 0, 0),
         mk(OP_TICK,  -1000000, -32768, -32768,     0, -1800, 1, 2047,    0, 1, 0,    0, 0, 0),
         mk(OP_TICK,         0,      0,      0,   799,  -799, 0,    0, 1000, 0, 0,    0, 0, 0),
         mk(OP_SWITCH,   12345,      0,      0,     0,     0, 1, 1500,  777, 1, 0,  777, 1, 0),
         mk(OP_APPLY,        0,      0,      0,     0,     0, 0, 1500,  900, 1, 0, 1500, 1, 0),
         mk(OP_TICK,  -1000000, -32768,  32767,     0,     0, 0,    0,  100, 0, 0,    0, 0, 0),
         mk(OP_TICK,  -1000000, -32768,  32767,     0,     0, 0,    0,  100, 0, 0,    0, 0, 0),
         mk(OP_TICK,   1000000,  32767, -32768,  -799,   799, 0,    0,  100, 0, 0,    0, 0, 0),
         mk(OP_APPLY,        0,      0,      0,     0,     0, 0, 2047,   20, 0, 0,    0, 0, 0),
         mk(OP_APPLY,        0,      0,      0,     0,     0, 0,    0, 2047, 0, 0,    0, 0, 0),
         mk(OP_APPLY,   -77777,      0,      0,     0,     0, 0, 1510, 1600, 0, 0,    0, 0, 0),
         mk(OP_TICK,       500,    100,     -5, -1800,  1800, 0,    0, 1999, 1, 0, 1999, 1, 0),
         mk(OP_SWITCH,       0,      0,      0,     0,     0, 0,    0,   55, 1, 0,   55, 0, 0),
         mk(OP_SWITCH,       0,      0,      0,     0,     0, 1,    0,   66, 1, 0,   66, 1, 0),
         mk(OP_SWITCH,       0,      0,      0,     0,     0, 1, 2000,   77, 1, 0,   77, 1, 0),
         mk(OP_APPLY,        0,      0,      0,     0,     0, 0,    0,    0, 1, 0, 1150, 1, 0),
         mk(OP_SWITCH,       0,      0,      0,     0,     0, 0,    0,    1, 1, 0,    1, 0, 0),
         mk(OP_SWITCH,       0,      0,      0,     0,     0, 1, 2047,    2, 1, 0,    2, 1, 0),
         mk(OP_APPLY,        0,      0,      0,     0,     0, 0, 2047,    3, 1, 0, 1850, 1, 0),
         mk(OP_NOP,     -54321,    -11,     22,  -333,   444, 1,  100, 2047, 1, 0, 2047, 1, 0),
         mk(OP_TICK,     12345,      0,      0,     0,     0, 0,    0,  500, 0, 0,    0, 0, 0),
         mk(OP_APPLY,        0,      0,      0,     0,     0, 0, 1000,  600, 0, 0,    0, 0, 0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
      req_if.valid <= 1'b0;

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         drain();
         foreach (REG_ORDER[r]) begin
            v = SETTINGS_TABLE[p][r];
            if (v < 0) begin
               case (REG_ORDER[r])
                  CSR_FAST:                 v = $urandom_range(0, 1);
                  CSR_THR_MIN, CSR_THR_MAX: v = $urandom_range(0, THR_CEIL);
                  default:                  v = $urandom_range(0, 255);
               endcase
            end
            write_reg(REG_ORDER[r], v);
         end
         csr_if.valid <= 1'b0;
         alt_home = srand(900000);
         for (int n = 0; n < WORDS_PER_SETTING; n++) begin
            if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            send_word(random_word(), 1'b0, none);
         end
         req_if.valid <= 1'b0;
      end

      calm = 1'b0;
      drain();
      repeat (20) @(posedge clock);
      $display("%0d words checked across %0d register settings plus directed cases",
               words_done, NUM_SETTINGS);
      $display("%0d mismatches in %0d cycles", errors, cycles);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

// ----- altitude_hold_cascaded_pid_top.f -----
+incdir+sv
sv/ahcp_pkg.sv
sv/ahcp_ifs.sv
sv/altitude_hold_cascaded_pid_top.sv
sv/ahcp_checker.sv
dv/tb_altitude_hold_cascaded_pid_top.sv
